### src/json_top_level_splitter_assert.svh
// Assertion macros shared by the splitter RTL.
`ifndef JSON_TOP_LEVEL_SPLITTER_ASSERT_SVH
`define JSON_TOP_LEVEL_SPLITTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define JTLS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("splitter assertion failed");

// Next-cycle implication, disabled during reset.
`define JTLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("splitter assertion failed");

`endif

### src/jtls_pkg.sv
// Package: types, constants and byte classifier for the JSON splitter.
package jtls_pkg;

   localparam int POS_BITS_DEFAULT   = 16;
   localparam int DEPTH_BITS_DEFAULT = 8;
   localparam int OUT_POS_BITS       = 16;
   localparam int POS_WIDE_BITS      = 32;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACKET  = 8'h5D;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;

   typedef enum logic [2:0] {
      CLS_PLAIN,
      CLS_OPEN,
      CLS_CLOSE,
      CLS_COMMA,
      CLS_COLON
   } tok_class_type;

   typedef enum logic [1:0] {
      KIND_STRING  = 2'd0,
      KIND_TABLE   = 2'd1,
      KIND_PAIR    = 2'd2,
      KIND_INVALID = 2'd3
   } kind_type;

   // Token handed from front to back (position travels beside it).
   typedef struct packed {
      tok_class_type cls;
      logic          last;
   } tok_ctrl_type;

   localparam int CTRL_BITS = $bits(tok_ctrl_type);

   // Structural class of a byte seen outside quotes and escapes.
   function automatic tok_class_type classify(input logic [7:0] c);
      tok_class_type r;
      r = CLS_PLAIN;
      if (c == CH_LBRACKET || c == CH_LBRACE) begin
         r = CLS_OPEN;
      end else if (c == CH_RBRACKET || c == CH_RBRACE) begin
         r = CLS_CLOSE;
      end else if (c == CH_COMMA) begin
         r = CLS_COMMA;
      end else if (c == CH_COLON) begin
         r = CLS_COLON;
      end
      return r;
   endfunction

endpackage

### src/json_top_level_splitter.sv
// JSON top-level splitter: per-byte structural tokenizer with element output.
// Throughput: one request per cycle while results are taken; a front classifier feeds a
// two-entry token queue that a back tracker drains at one token per cycle unless a held result stalls it.
// Path: an accepted request is held in the token queue until the back end pops it;
// its result (if any) is registered at the pop and held until it is taken.
// Reset: synchronous, active high; clears position, quote, depth, kind and abort state.
module json_top_level_splitter #(
   parameter int POS_BITS   = jtls_pkg::POS_BITS_DEFAULT,
   parameter int DEPTH_BITS = jtls_pkg::DEPTH_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel: one document byte per request
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        req_is_last,
   // result channel: one element per result
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_elem_start,
   output logic [15:0] rsp_elem_end,
   output logic [1:0]  rsp_elem_kind,
   output logic        rsp_closes_document
);

   // Queue word: token control on top, byte position below.
   localparam int QBits = jtls_pkg::CTRL_BITS + POS_BITS;

   logic                   q_full, q_valid, push, pop;
   jtls_pkg::tok_ctrl_type push_ctrl, pop_ctrl;
   logic [POS_BITS-1:0]    push_pos, pop_pos;
   logic [QBits-1:0]       push_word, pop_word;

   // Front: tracks quotes/escapes and position, classifies each byte.
   jtls_front #(
      .POS_BITS (POS_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_byte   (req_text_byte),
      .in_last   (req_is_last),
      .q_full    (q_full),
      .in_ready  (req_ready),
      .push      (push),
      .push_ctrl (push_ctrl),
      .push_pos  (push_pos)
   );

   assign push_word = {push_ctrl, push_pos};

   // Decoupling queue lets the front keep taking bytes while results stall.
   jtls_queue #(
      .DATA_BITS (QBits)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_word),
      .pop       (pop),
      .full      (q_full),
      .q_valid   (q_valid),
      .q_data    (pop_word)
   );

   assign pop_ctrl = jtls_pkg::tok_ctrl_type'(pop_word[QBits-1 -: jtls_pkg::CTRL_BITS]);
   assign pop_pos  = pop_word[POS_BITS-1:0];

   // Back: depth, kind and top-level split; owns the result register.
   jtls_back #(
      .POS_BITS   (POS_BITS),
      .DEPTH_BITS (DEPTH_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (q_valid),
      .tok_ctrl  (pop_ctrl),
      .tok_pos   (pop_pos),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_start (rsp_elem_start),
      .out_end   (rsp_elem_end),
      .out_kind  (rsp_elem_kind),
      .out_close (rsp_closes_document)
   );

endmodule

### src/jtls_front.sv
// Front end: quote/escape tracking, byte position, structural classification.
module jtls_front #(
   parameter int POS_BITS = jtls_pkg::POS_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   input  logic                 q_full,
   output logic                 in_ready,
   output logic                 push,
   output jtls_pkg::tok_ctrl_type push_ctrl,
   output logic [POS_BITS-1:0]  push_pos
);

   logic                quote_ff, quote_in;
   logic                esc_ff, esc_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   jtls_pkg::tok_class_type cls;

   assign in_ready = !q_full;
   assign push     = in_valid && in_ready;

   always_comb begin
      quote_in = quote_ff;
      esc_in   = esc_ff;
      pos_in   = pos_ff;
      cls      = jtls_pkg::CLS_PLAIN;
      if (push) begin
         if (esc_ff) begin
            esc_in = 1'b0;
         end else if (quote_ff) begin
            if (in_byte == jtls_pkg::CH_BACKSLASH) begin
               esc_in = !in_last;
            end else if (in_byte == jtls_pkg::CH_QUOTE) begin
               quote_in = 1'b0;
            end
         end else if (in_byte == jtls_pkg::CH_BACKSLASH) begin
            esc_in = !in_last;
         end else if (in_byte == jtls_pkg::CH_QUOTE) begin
            quote_in = 1'b1;
         end else begin
            cls = jtls_pkg::classify(in_byte);
         end
         pos_in = pos_ff + POS_BITS'(1);
         if (in_last) begin
            quote_in = 1'b0;
            esc_in   = 1'b0;
            pos_in   = '0;
         end
      end
   end

   assign push_ctrl.cls  = cls;
   assign push_ctrl.last = in_last;
   assign push_pos       = pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff <= 1'b0;
         esc_ff   <= 1'b0;
         pos_ff   <= '0;
      end else begin
         quote_ff <= quote_in;
         esc_ff   <= esc_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

### src/jtls_queue.sv
// Short token queue between front and back.
`include "json_top_level_splitter_assert.svh"
module jtls_queue #(
   parameter int DATA_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 q_valid,
   output logic [DATA_BITS-1:0] q_data
);

   localparam int Depth    = jtls_pkg::QUEUE_DEPTH;
   localparam int PtrBits  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntBits  = $clog2(Depth + 1);

   logic [DATA_BITS-1:0] slot_ff [Depth];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0]   count_ff, count_in;

   assign full    = (count_ff == CntBits'(Depth));
   assign q_valid = (count_ff != '0);
   assign q_data  = slot_ff[rd_ptr_ff];

   function automatic logic [PtrBits-1:0] ptr_next(input logic [PtrBits-1:0] p);
      logic [PtrBits-1:0] r;
      r = (p == PtrBits'(Depth - 1)) ? '0 : p + PtrBits'(1);
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CntBits'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `JTLS_ASSERT_SAME(a_q_no_overflow, clock, reset, push, !full)
   `JTLS_ASSERT_SAME(a_q_no_underflow, clock, reset, pop, q_valid)
   `JTLS_ASSERT_SAME(a_q_count_range, clock, reset, 1'b1, count_ff <= CntBits'(Depth))

endmodule

### src/jtls_back.sv
// Back end: nesting depth, element kind, splitting and result register.
`include "json_top_level_splitter_assert.svh"
module jtls_back #(
   parameter int POS_BITS   = jtls_pkg::POS_BITS_DEFAULT,
   parameter int DEPTH_BITS = jtls_pkg::DEPTH_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tok_valid,
   input  jtls_pkg::tok_ctrl_type tok_ctrl,
   input  logic [POS_BITS-1:0]   tok_pos,
   output logic                  pop,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [jtls_pkg::OUT_POS_BITS-1:0] out_start,
   output logic [jtls_pkg::OUT_POS_BITS-1:0] out_end,
   output logic [1:0]            out_kind,
   output logic                  out_close
);

   localparam logic [DEPTH_BITS-1:0] DepthMax = {DEPTH_BITS{1'b1}};

   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic [POS_BITS-1:0]   begin_ff, begin_in;
   jtls_pkg::kind_type    kind_ff, kind_in;
   logic                  aborted_ff, aborted_in;

   logic                  emit, split;
   logic [POS_BITS-1:0]   e_start, e_end;
   jtls_pkg::kind_type    e_kind;
   logic                  e_close;
   logic [jtls_pkg::POS_WIDE_BITS-1:0] start_wide, end_wide;

   logic                  valid_ff, valid_in;
   logic [jtls_pkg::OUT_POS_BITS-1:0] start_ff, end_ff;
   logic [1:0]            kind_out_ff;
   logic                  close_ff;

   // A token pops when the result slot is empty or the held result is taken in the same cycle.
   assign pop = tok_valid && (!valid_ff || out_ready);

   always_comb begin
      depth_in   = depth_ff;
      begin_in   = begin_ff;
      kind_in    = kind_ff;
      aborted_in = aborted_ff;
      emit       = 1'b0;
      split      = 1'b0;
      e_start    = '0;
      e_end      = '0;
      e_kind     = jtls_pkg::KIND_STRING;
      e_close    = 1'b0;
      if (pop && !aborted_ff) begin
         unique case (tok_ctrl.cls)
            jtls_pkg::CLS_OPEN: begin
               if (kind_ff == jtls_pkg::KIND_STRING) kind_in = jtls_pkg::KIND_TABLE;
               if (depth_ff != DepthMax) depth_in = depth_ff + DEPTH_BITS'(1);
            end
            jtls_pkg::CLS_COLON: begin
               if (kind_ff == jtls_pkg::KIND_STRING) kind_in = jtls_pkg::KIND_PAIR;
            end
            jtls_pkg::CLS_CLOSE: begin
               if (depth_ff != '0) begin
                  depth_in = depth_ff - DEPTH_BITS'(1);
               end else begin
                  emit       = 1'b1;
                  e_kind     = jtls_pkg::KIND_INVALID;
                  e_close    = tok_ctrl.last;
                  aborted_in = 1'b1;
               end
            end
            jtls_pkg::CLS_COMMA: begin
               if (depth_ff == '0) begin
                  emit     = 1'b1;
                  split    = 1'b1;
                  e_start  = begin_ff;
                  e_end    = tok_pos;
                  e_kind   = kind_ff;
                  e_close  = tok_ctrl.last;
                  begin_in = tok_pos + POS_BITS'(1);
                  kind_in  = jtls_pkg::KIND_STRING;
               end
            end
            default: begin
            end
         endcase
         if (tok_ctrl.last && !aborted_in && !split) begin
            emit    = 1'b1;
            e_start = begin_ff;
            e_end   = tok_pos + POS_BITS'(1);
            e_kind  = kind_in;
            e_close = 1'b1;
         end
      end
      if (pop && tok_ctrl.last) begin
         depth_in   = '0;
         begin_in   = '0;
         kind_in    = jtls_pkg::KIND_STRING;
         aborted_in = 1'b0;
      end
   end

   assign start_wide = jtls_pkg::POS_WIDE_BITS'(e_start);
   assign end_wide   = jtls_pkg::POS_WIDE_BITS'(e_end);
   assign valid_in   = pop ? emit : (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff   <= '0;
         begin_ff   <= '0;
         kind_ff    <= jtls_pkg::KIND_STRING;
         aborted_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         depth_ff   <= depth_in;
         begin_ff   <= begin_in;
         kind_ff    <= kind_in;
         aborted_ff <= aborted_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         start_ff    <= start_wide[jtls_pkg::OUT_POS_BITS-1:0];
         end_ff      <= end_wide[jtls_pkg::OUT_POS_BITS-1:0];
         kind_out_ff <= e_kind;
         close_ff    <= e_close;
      end
   end

   assign out_valid = valid_ff;
   assign out_start = start_ff;
   assign out_end   = end_ff;
   assign out_kind  = kind_out_ff;
   assign out_close = close_ff;

   `JTLS_ASSERT_NEXT(a_emit_lands, clock, reset, pop && emit, valid_ff)
   `JTLS_ASSERT_SAME(a_no_emit_aborted, clock, reset, aborted_ff, !emit)
   `JTLS_ASSERT_NEXT(a_doc_end_clears, clock, reset, pop && tok_ctrl.last,
                     !aborted_ff && depth_ff == '0 && kind_ff == jtls_pkg::KIND_STRING)
   `JTLS_ASSERT_NEXT(a_depth_saturates, clock, reset,
                     pop && !aborted_ff && !tok_ctrl.last && depth_ff == DepthMax &&
                     tok_ctrl.cls == jtls_pkg::CLS_OPEN, depth_ff == DepthMax)

endmodule
